@@ design/neighbourhood_texture_histogram_core_macros.svh @@
// Assertion helpers used by the histogram core.
`ifndef NEIGHBOURHOOD_TEXTURE_HISTOGRAM_CORE_MACROS_SVH
`define NEIGHBOURHOOD_TEXTURE_HISTOGRAM_CORE_MACROS_SVH

// Same-cycle implication.
`define NTH_ASSERT_IMPLY(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

// Next-cycle implication.
`define NTH_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

@@ design/nth_pkg.sv @@
package nth_pkg;

   localparam int CFG_BITS   = 11;
   localparam int OUT_BITS   = 20;
   localparam int LUMA_BITS  = 8;
   localparam int CODE_BITS  = 8;
   localparam int NUM_BINS   = 256;
   localparam int SUM5_BITS  = 11;
   localparam int REF3_BITS  = 12;
   localparam int TRI_BITS   = 10;
   localparam int DIV5_BITS  = 13;
   localparam int PROD_BITS  = REF3_BITS + DIV5_BITS;
   localparam int DIV5_SHIFT = 15;
   // floor(x / 5) == (x * 6554) >> 15 for x below 16384
   localparam logic [DIV5_BITS-1:0] DIV5_MUL = 13'd6554;

   typedef enum logic [1:0] {
      ACT_PIXEL = 2'd0,
      ACT_READ  = 2'd1,
      ACT_CLEAR = 2'd2
   } action_type;

   typedef enum logic [0:0] {
      REG_IMAGE_WIDTH  = 1'b0,
      REG_IMAGE_HEIGHT = 1'b1
   } reg_index_type;

   // [row][column], row 0 is two lines above the newest pixel, column 2 the newest pixel
   typedef logic [2:0][2:0][LUMA_BITS-1:0] window_type;

endpackage

@@ design/nth_ram.sv @@
module nth_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 1024
) (
   input  logic                             clock,
   input  logic                             wr_en,
   input  logic [$clog2(DEPTH)-1:0]         wr_addr,
   input  logic [WIDTH-1:0]                 wr_data,
   input  logic                             rd_en,
   input  logic [$clog2(DEPTH)-1:0]         rd_addr,
   output logic [WIDTH-1:0]                 rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

@@ design/nth_code.sv @@
module nth_code import nth_pkg::*; (
   input  logic                 clock,
   input  window_type           window,
   output logic [CODE_BITS-1:0] code
);

   logic [LUMA_BITS-1:0] ul, u, ur, l, ce, r, dl, d, dr;
   logic [SUM5_BITS-1:0] sum5;
   logic [7:0][TRI_BITS-1:0] tri_in;
   logic [7:0][TRI_BITS-1:0] tri_ff;
   logic [REF3_BITS-1:0] ref3_in;
   logic [REF3_BITS-1:0] ref3_ff;
   logic [PROD_BITS-1:0] prod;
   logic [TRI_BITS-1:0]  ref_val;
   logic [CODE_BITS-1:0] code_in;
   logic [CODE_BITS-1:0] code_ff;

   assign ul = window[0][0];
   assign u  = window[0][1];
   assign ur = window[0][2];
   assign l  = window[1][0];
   assign ce = window[1][1];
   assign r  = window[1][2];
   assign dl = window[2][0];
   assign d  = window[2][1];
   assign dr = window[2][2];

   // stage 1: five-pixel sum times 3, eight three-pixel sums
   always_comb begin
      sum5 = SUM5_BITS'(l) + SUM5_BITS'(ce) + SUM5_BITS'(r) + SUM5_BITS'(u) + SUM5_BITS'(d);
      ref3_in = REF3_BITS'(sum5) + REF3_BITS'({sum5, 1'b0});
      tri_in[7] = TRI_BITS'(l)  + TRI_BITS'(ul) + TRI_BITS'(u);
      tri_in[6] = TRI_BITS'(ul) + TRI_BITS'(u)  + TRI_BITS'(ur);
      tri_in[5] = TRI_BITS'(r)  + TRI_BITS'(ur) + TRI_BITS'(u);
      tri_in[4] = TRI_BITS'(ul) + TRI_BITS'(l)  + TRI_BITS'(dl);
      tri_in[3] = TRI_BITS'(ur) + TRI_BITS'(r)  + TRI_BITS'(dr);
      tri_in[2] = TRI_BITS'(l)  + TRI_BITS'(dl) + TRI_BITS'(d);
      tri_in[1] = TRI_BITS'(dl) + TRI_BITS'(d)  + TRI_BITS'(dr);
      tri_in[0] = TRI_BITS'(r)  + TRI_BITS'(dr) + TRI_BITS'(d);
   end

   // stage 2: divide by 5 through the reciprocal, then compare
   always_comb begin
      prod = PROD_BITS'(ref3_ff) * PROD_BITS'(DIV5_MUL);
      ref_val = TRI_BITS'(prod >> DIV5_SHIFT);
      for (int i = 0; i < CODE_BITS; i++) begin
         code_in[i] = (tri_ff[i] < ref_val);
      end
   end

   always_ff @(posedge clock) begin
      ref3_ff <= ref3_in;
      tri_ff  <= tri_in;
      code_ff <= code_in;
   end

   assign code = code_ff;

endmodule

@@ design/neighbourhood_texture_histogram_core.sv @@
// Channel   Direction  Handshake               Payload
// req_      in         req_valid / req_ready   req_action, req_luma, req_bin_select
// rsp_      out        rsp_valid / rsp_ready   rsp_bin_count, rsp_interior_pixels
// csr_      in         csr_write_enable        csr_index, csr_write_data
//
// One request at a time; req_ready is high while no request is in work.
// Pixel counted in the histogram: line store read, two code stages, bin read,
// bin write. Border pixel: line store read only. Ignored pixel or clear: done
// on acceptance. A bin read waits while the result register is still full.
// Synchronous reset clears control, window, counts and bin valid bits at once;
// line stores are not cleared. A stalled result does not block pixel requests.
module neighbourhood_texture_histogram_core import nth_pkg::*; #(
   parameter int MAX_WIDTH  = 1024,
   parameter int MAX_HEIGHT = 1024,
   parameter int COUNT_BITS = 20
) (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 req_valid,
   output logic                 req_ready,
   input  logic [1:0]           req_action,
   input  logic [LUMA_BITS-1:0] req_luma,
   input  logic [CODE_BITS-1:0] req_bin_select,
   output logic                 rsp_valid,
   input  logic                 rsp_ready,
   output logic [OUT_BITS-1:0]  rsp_bin_count,
   output logic [OUT_BITS-1:0]  rsp_interior_pixels,
   input  logic                 csr_write_enable,
   input  logic [0:0]           csr_index,
   input  logic [CFG_BITS-1:0]  csr_write_data
);

   `include "neighbourhood_texture_histogram_core_macros.svh"

   localparam int AW    = $clog2(MAX_WIDTH);
   localparam int WB    = $clog2(MAX_WIDTH + 1);
   localparam int RB    = $clog2(MAX_HEIGHT + 1);
   localparam int EXT_W = (WB > CFG_BITS) ? WB : CFG_BITS;
   localparam int EXT_H = (RB > CFG_BITS) ? RB : CFG_BITS;
   localparam int LINE_BITS = 2 * LUMA_BITS;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_LINE,
      ST_CODE1,
      ST_CODE2,
      ST_BIN_RD,
      ST_BIN_WR,
      ST_READ
   } state_type;

   state_type               state_ff, state_in;
   logic [CFG_BITS-1:0]     image_width_ff, image_width_in;
   logic [CFG_BITS-1:0]     image_height_ff, image_height_in;
   logic [AW-1:0]           col_ff, col_in;
   logic [RB-1:0]           row_ff, row_in;
   logic [AW-1:0]           pix_col_ff, pix_col_in;
   logic [LUMA_BITS-1:0]    luma_ff, luma_in;
   logic                    count_ff, count_in;
   logic [CODE_BITS-1:0]    sel_ff, sel_in;
   window_type              window_ff, window_in;
   logic [NUM_BINS-1:0]     bin_valid_ff, bin_valid_in;
   logic [COUNT_BITS-1:0]   interior_ff, interior_in;
   logic                    rsp_valid_ff, rsp_valid_in;
   logic [OUT_BITS-1:0]     rsp_bin_count_ff, rsp_bin_count_in;
   logic [OUT_BITS-1:0]     rsp_interior_ff, rsp_interior_in;

   logic [EXT_W-1:0]        width_ext;
   logic [EXT_H-1:0]        height_ext;
   logic [WB-1:0]           w_eff;
   logic [RB-1:0]           h_eff;
   logic                    col_wrap;
   logic [AW-1:0]           col_e;
   logic [RB-1:0]           row_e;
   logic [WB-1:0]           col_next;
   logic                    accept;

   logic                    line_rd_en, line_wr_en;
   logic [LINE_BITS-1:0]    line_rd_data, line_wr_data;
   logic                    bin_rd_en, bin_wr_en;
   logic [CODE_BITS-1:0]    bin_rd_addr;
   logic [COUNT_BITS-1:0]   bin_rd_data, bin_wr_data;
   logic [COUNT_BITS-1:0]   bin_cur;
   logic [COUNT_BITS-1:0]   sel_cur;
   logic [OUT_BITS-1:0]     sel_out, interior_out;
   logic [CODE_BITS-1:0]    code;

   nth_ram #(.WIDTH(LINE_BITS), .DEPTH(MAX_WIDTH)) u_line_ram (
      .clock   (clock),
      .wr_en   (line_wr_en),
      .wr_addr (pix_col_ff),
      .wr_data (line_wr_data),
      .rd_en   (line_rd_en),
      .rd_addr (col_e),
      .rd_data (line_rd_data)
   );

   nth_ram #(.WIDTH(COUNT_BITS), .DEPTH(NUM_BINS)) u_bin_ram (
      .clock   (clock),
      .wr_en   (bin_wr_en),
      .wr_addr (code),
      .wr_data (bin_wr_data),
      .rd_en   (bin_rd_en),
      .rd_addr (bin_rd_addr),
      .rd_data (bin_rd_data)
   );

   nth_code u_code (
      .clock  (clock),
      .window (window_ff),
      .code   (code)
   );

   // effective frame size
   always_comb begin
      width_ext  = EXT_W'(image_width_ff);
      height_ext = EXT_H'(image_height_ff);
      priority if (width_ext == '0) begin
         w_eff = WB'(1);
      end else if (width_ext > EXT_W'(MAX_WIDTH)) begin
         w_eff = WB'(MAX_WIDTH);
      end else begin
         w_eff = WB'(width_ext);
      end
      if (height_ext > EXT_H'(MAX_HEIGHT)) begin
         h_eff = RB'(MAX_HEIGHT);
      end else begin
         h_eff = RB'(height_ext);
      end
   end

   // position of the pixel in the current request, after a late line end
   always_comb begin
      col_wrap = (WB'(col_ff) >= w_eff);
      col_e    = col_wrap ? '0 : col_ff;
      row_e    = (col_wrap && (row_ff < RB'(MAX_HEIGHT))) ? row_ff + RB'(1) : row_ff;
      col_next = WB'(col_e) + WB'(1);
   end

   generate
      if (COUNT_BITS >= OUT_BITS) begin : g_out_trunc
         assign sel_out      = sel_cur[OUT_BITS-1:0];
         assign interior_out = interior_ff[OUT_BITS-1:0];
      end else begin : g_out_ext
         assign sel_out      = {{(OUT_BITS - COUNT_BITS){1'b0}}, sel_cur};
         assign interior_out = {{(OUT_BITS - COUNT_BITS){1'b0}}, interior_ff};
      end
   endgenerate

   assign req_ready    = (state_ff == ST_IDLE);
   assign accept       = req_valid && req_ready;
   assign line_wr_data = {line_rd_data[LUMA_BITS-1:0], luma_ff};
   assign bin_cur      = bin_valid_ff[code] ? bin_rd_data : '0;
   assign sel_cur      = bin_valid_ff[sel_ff] ? bin_rd_data : '0;
   assign bin_wr_data  = (bin_cur != '1) ? bin_cur + COUNT_BITS'(1) : bin_cur;
   assign bin_wr_en    = (state_ff == ST_BIN_WR);
   assign line_wr_en   = (state_ff == ST_LINE);
   assign bin_rd_addr  = (state_ff == ST_BIN_RD) ? code : req_bin_select;

   always_comb begin
      state_in         = state_ff;
      image_width_in   = image_width_ff;
      image_height_in  = image_height_ff;
      col_in           = col_ff;
      row_in           = row_ff;
      pix_col_in       = pix_col_ff;
      luma_in          = luma_ff;
      count_in         = count_ff;
      sel_in           = sel_ff;
      window_in        = window_ff;
      bin_valid_in     = bin_valid_ff;
      interior_in      = interior_ff;
      rsp_valid_in     = rsp_valid_ff && !rsp_ready;
      rsp_bin_count_in = rsp_bin_count_ff;
      rsp_interior_in  = rsp_interior_ff;
      line_rd_en       = 1'b0;
      bin_rd_en        = 1'b0;

      if (csr_write_enable) begin
         unique case (csr_index)
            REG_IMAGE_WIDTH:  image_width_in  = csr_write_data;
            REG_IMAGE_HEIGHT: image_height_in = csr_write_data;
         endcase
      end

      unique case (state_ff)
         ST_IDLE: begin
            if (accept) begin
               unique case (req_action)
                  ACT_PIXEL: begin
                     col_in = col_e;
                     row_in = row_e;
                     if (row_e < h_eff) begin
                        line_rd_en = 1'b1;
                        pix_col_in = col_e;
                        luma_in    = req_luma;
                        count_in   = (w_eff >= WB'(4)) && (h_eff >= RB'(4)) &&
                                     (row_e >= RB'(2)) && (col_e >= AW'(2));
                        state_in   = ST_LINE;
                        if (col_next >= w_eff) begin
                           col_in = '0;
                           row_in = (row_e < RB'(MAX_HEIGHT)) ? row_e + RB'(1) : row_e;
                        end else begin
                           col_in = AW'(col_next);
                        end
                     end
                  end
                  ACT_READ: begin
                     bin_rd_en = 1'b1;
                     sel_in    = req_bin_select;
                     state_in  = ST_READ;
                  end
                  ACT_CLEAR: begin
                     col_in       = '0;
                     row_in       = '0;
                     window_in    = '0;
                     bin_valid_in = '0;
                     interior_in  = '0;
                  end
                  default: begin
                  end
               endcase
            end
         end
         ST_LINE: begin
            for (int i = 0; i < 3; i++) begin
               window_in[i][0] = window_ff[i][1];
               window_in[i][1] = window_ff[i][2];
            end
            window_in[0][2] = line_rd_data[LINE_BITS-1:LUMA_BITS];
            window_in[1][2] = line_rd_data[LUMA_BITS-1:0];
            window_in[2][2] = luma_ff;
            state_in = count_ff ? ST_CODE1 : ST_IDLE;
         end
         ST_CODE1: begin
            state_in = ST_CODE2;
         end
         ST_CODE2: begin
            state_in = ST_BIN_RD;
         end
         ST_BIN_RD: begin
            bin_rd_en = 1'b1;
            state_in  = ST_BIN_WR;
         end
         ST_BIN_WR: begin
            bin_valid_in[code] = 1'b1;
            if (interior_ff != '1) begin
               interior_in = interior_ff + COUNT_BITS'(1);
            end
            state_in = ST_IDLE;
         end
         ST_READ: begin
            if (!rsp_valid_ff || rsp_ready) begin
               rsp_valid_in     = 1'b1;
               rsp_bin_count_in = sel_out;
               rsp_interior_in  = interior_out;
               state_in         = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff        <= ST_IDLE;
         image_width_ff  <= CFG_BITS'(64);
         image_height_ff <= CFG_BITS'(64);
         col_ff          <= '0;
         row_ff          <= '0;
         count_ff        <= 1'b0;
         window_ff       <= '0;
         bin_valid_ff    <= '0;
         interior_ff     <= '0;
         rsp_valid_ff    <= 1'b0;
      end else begin
         state_ff        <= state_in;
         image_width_ff  <= image_width_in;
         image_height_ff <= image_height_in;
         col_ff          <= col_in;
         row_ff          <= row_in;
         count_ff        <= count_in;
         window_ff       <= window_in;
         bin_valid_ff    <= bin_valid_in;
         interior_ff     <= interior_in;
         rsp_valid_ff    <= rsp_valid_in;
      end
      pix_col_ff       <= pix_col_in;
      luma_ff          <= luma_in;
      sel_ff           <= sel_in;
      rsp_bin_count_ff <= rsp_bin_count_in;
      rsp_interior_ff  <= rsp_interior_in;
   end

   assign rsp_valid           = rsp_valid_ff;
   assign rsp_bin_count       = rsp_bin_count_ff;
   assign rsp_interior_pixels = rsp_interior_ff;

   `NTH_ASSERT_IMPLY(a_rsp_from_read, clock, reset, $rose(rsp_valid_ff), $past(state_ff == ST_READ), "result without a read request")
   `NTH_ASSERT_NEXT(a_interior_monotonic, clock, reset, !(accept && (req_action == ACT_CLEAR)), interior_ff >= $past(interior_ff), "interior count went down without a clear")
   `NTH_ASSERT_IMPLY(a_count_frame_size, clock, reset, state_ff == ST_BIN_WR, (w_eff >= WB'(4)) && (h_eff >= RB'(4)), "bin updated on a frame below 4x4")

endmodule

@@ dv/tb_neighbourhood_texture_histogram_core.sv @@
module tb_neighbourhood_texture_histogram_core import nth_pkg::*; ();

   timeunit 1ns;
   timeprecision 1ps;

   localparam int MAX_WIDTH    = 1024;
   localparam int MAX_HEIGHT   = 1024;
   localparam int LIMIT_CYCLES = 400000;
   localparam int DRAIN_CYCLES = 8;
   localparam logic [1:0] ACT_UNUSED = 2'd3;
   localparam logic [OUT_BITS-1:0] COUNT_FULL = {OUT_BITS{1'b1}};

   typedef struct {
      logic [1:0]           action;
      logic [LUMA_BITS-1:0] luma;
      logic [CODE_BITS-1:0] bin_select;
   } texture_request_type;

   typedef struct {
      logic [OUT_BITS-1:0] bin_count;
      logic [OUT_BITS-1:0] interior_pixels;
   } bin_read_type;

   logic                 clock = 1'b0;
   logic                 reset = 1'b1;
   logic                 req_valid = 1'b0;
   logic                 req_ready;
   logic [1:0]           req_action = ACT_PIXEL;
   logic [LUMA_BITS-1:0] req_luma = '0;
   logic [CODE_BITS-1:0] req_bin_select = '0;
   logic                 rsp_valid;
   logic                 rsp_ready = 1'b0;
   logic [OUT_BITS-1:0]  rsp_bin_count;
   logic [OUT_BITS-1:0]  rsp_interior_pixels;
   logic                 csr_write_enable = 1'b0;
   logic [0:0]           csr_index = REG_IMAGE_WIDTH;
   logic [CFG_BITS-1:0]  csr_write_data = '0;

   neighbourhood_texture_histogram_core dut (
      .clock               (clock),
      .reset               (reset),
      .req_valid           (req_valid),
      .req_ready           (req_ready),
      .req_action          (req_action),
      .req_luma            (req_luma),
      .req_bin_select      (req_bin_select),
      .rsp_valid           (rsp_valid),
      .rsp_ready           (rsp_ready),
      .rsp_bin_count       (rsp_bin_count),
      .rsp_interior_pixels (rsp_interior_pixels),
      .csr_write_enable    (csr_write_enable),
      .csr_index           (csr_index),
      .csr_write_data      (csr_write_data)
   );

   always #10ns clock = ~clock;

   texture_request_type queued_requests[$];
   bin_read_type        due_reads[$];
   texture_request_type presented;

   int sender_idle_pct    = 0;
   int receiver_stall_pct = 0;
   int error_count        = 0;
   int cycle_count        = 0;
   int pixel_count        = 0;
   int read_count         = 0;
   int setting_count      = 0;

   // shadow of the block state
   logic [CFG_BITS-1:0]  width_reg  = 11'd64;
   logic [CFG_BITS-1:0]  height_reg = 11'd64;
   logic [LUMA_BITS-1:0] above_line [MAX_WIDTH];
   logic [LUMA_BITS-1:0] middle_line [MAX_WIDTH];
   window_type           win = '0;
   int unsigned          col_pos = 0;
   int unsigned          row_pos = 0;
   logic [OUT_BITS-1:0]  bin_counts [NUM_BINS];
   logic [OUT_BITS-1:0]  interior_total = '0;

   function automatic int unsigned frame_width(logic [CFG_BITS-1:0] w);
      if (w == 0) return 1;
      if (w > MAX_WIDTH) return MAX_WIDTH;
      return 32'(w);
   endfunction

   function automatic int unsigned frame_height(logic [CFG_BITS-1:0] h);
      if (h > MAX_HEIGHT) return MAX_HEIGHT;
      return 32'(h);
   endfunction

   function automatic logic [CODE_BITS-1:0] texture_code(window_type w);
      int unsigned ul, u, ur, l, ce, r, dl, d, dr, ref_level;
      logic [CODE_BITS-1:0] code;
      ul = 32'(w[0][0]); u  = 32'(w[0][1]); ur = 32'(w[0][2]);
      l  = 32'(w[1][0]); ce = 32'(w[1][1]); r  = 32'(w[1][2]);
      dl = 32'(w[2][0]); d  = 32'(w[2][1]); dr = 32'(w[2][2]);
      ref_level = (l + ce + r + u + d) * 3 / 5;
      code = '0;
      if (l + ul + u < ref_level) code |= 8'h80;
      if (ul + u + ur < ref_level) code |= 8'h40;
      if (r + ur + u < ref_level) code |= 8'h20;
      if (ul + l + dl < ref_level) code |= 8'h10;
      if (ur + r + dr < ref_level) code |= 8'h08;
      if (l + dl + d < ref_level) code |= 8'h04;
      if (dl + d + dr < ref_level) code |= 8'h02;
      if (r + dr + d < ref_level) code |= 8'h01;
      return code;
   endfunction

   task automatic next_row();
      col_pos = 0;
      if (row_pos < MAX_HEIGHT) row_pos++;
   endtask

   task automatic restart_histogram();
      col_pos = 0;
      row_pos = 0;
      win = '0;
      foreach (bin_counts[i]) bin_counts[i] = '0;
      interior_total = '0;
   endtask

   task automatic accumulate_pixel(logic [LUMA_BITS-1:0] luma);
      int unsigned w, h, c;
      logic [CODE_BITS-1:0] code;
      w = frame_width(width_reg);
      h = frame_height(height_reg);
      if (col_pos >= w) next_row();
      if (row_pos >= h) return;
      c = col_pos;
      for (int i = 0; i < 3; i++) begin
         win[i][0] = win[i][1];
         win[i][1] = win[i][2];
      end
      win[0][2] = above_line[c];
      win[1][2] = middle_line[c];
      win[2][2] = luma;
      above_line[c] = middle_line[c];
      middle_line[c] = luma;
      if (w >= 4 && h >= 4 && row_pos >= 2 && c >= 2) begin
         code = texture_code(win);
         if (bin_counts[code] != COUNT_FULL) bin_counts[code]++;
         if (interior_total != COUNT_FULL) interior_total++;
      end
      col_pos = c + 1;
      if (col_pos >= w) next_row();
   endtask

   task automatic update_texture_histogram(texture_request_type rq);
      bin_read_type res;
      if (rq.action == ACT_PIXEL) begin
         accumulate_pixel(rq.luma);
         pixel_count++;
      end else if (rq.action == ACT_READ) begin
         res.bin_count = bin_counts[rq.bin_select];
         res.interior_pixels = interior_total;
         due_reads.push_back(res);
      end else if (rq.action == ACT_CLEAR) begin
         restart_histogram();
      end
   endtask

   always @(posedge clock) begin : driver
      if (reset) begin
         req_valid <= 1'b0;
      end else begin
         if (req_valid && req_ready) update_texture_histogram(presented);
         if (!req_valid || req_ready) begin
            if (queued_requests.size() != 0 && $urandom_range(99) >= sender_idle_pct) begin
               presented = queued_requests.pop_front();
               req_valid      <= 1'b1;
               req_action     <= presented.action;
               req_luma       <= presented.luma;
               req_bin_select <= presented.bin_select;
            end else begin
               req_valid <= 1'b0;
            end
         end
      end
   end

   always @(posedge clock) begin : monitor
      bin_read_type want;
      if (!reset && rsp_valid && rsp_ready) begin
         if (due_reads.size() == 0) begin
            $error("unexpected response: bin_count %0d interior_pixels %0d",
                   rsp_bin_count, rsp_interior_pixels);
            error_count++;
         end else begin
            want = due_reads.pop_front();
            read_count++;
            if (rsp_bin_count !== want.bin_count) begin
               $error("bin_count: expected %0d, actual %0d", want.bin_count, rsp_bin_count);
               error_count++;
            end
            if (rsp_interior_pixels !== want.interior_pixels) begin
               $error("interior_pixels: expected %0d, actual %0d",
                      want.interior_pixels, rsp_interior_pixels);
               error_count++;
            end
         end
      end
      rsp_ready <= ($urandom_range(99) >= receiver_stall_pct);
   end

   always @(posedge clock) begin : watchdog
      cycle_count++;
      if (cycle_count > LIMIT_CYCLES) begin
         $display("RESULT: ERROR");
         $finish;
      end
   end

   task automatic push_req(logic [1:0] action, logic [7:0] luma, logic [7:0] sel);
      texture_request_type rq;
      rq.action = action;
      rq.luma = luma;
      rq.bin_select = sel;
      queued_requests.push_back(rq);
   endtask

   task automatic queue_mix(int n, int read_pct, int clear_pct, int unused_pct);
      int r;
      logic [1:0] act;
      for (int i = 0; i < n; i++) begin
         r = $urandom_range(99);
         if (r < read_pct) act = ACT_READ;
         else if (r < read_pct + clear_pct) act = ACT_CLEAR;
         else if (r < read_pct + clear_pct + unused_pct) act = ACT_UNUSED;
         else act = ACT_PIXEL;
         push_req(act, 8'($urandom_range(255)), 8'($urandom_range(255)));
      end
   endtask

   // sender holds off until the block has gone quiet
   task automatic drain_block();
      @(posedge clock);
      #1;
      while (queued_requests.size() != 0 || req_valid || due_reads.size() != 0) begin
         @(posedge clock);
         #1;
      end
      repeat (DRAIN_CYCLES) @(posedge clock);
   endtask

   task automatic write_csr(reg_index_type idx, logic [CFG_BITS-1:0] data);
      @(posedge clock);
      csr_write_enable <= 1'b1;
      csr_index        <= idx;
      csr_write_data   <= data;
      @(posedge clock);
      csr_write_enable <= 1'b0;
      if (idx == REG_IMAGE_WIDTH) width_reg = data;
      else height_reg = data;
   endtask

   // a wider line would pick up stale line store entries, so restart the frame
   task automatic set_frame(logic [CFG_BITS-1:0] w, logic [CFG_BITS-1:0] h, bit fresh);
      int unsigned old_w;
      old_w = frame_width(width_reg);
      drain_block();
      case (setting_count % 4)
         0: begin sender_idle_pct = 0;  receiver_stall_pct = 0;  end
         1: begin sender_idle_pct = 68; receiver_stall_pct = 0;  end
         2: begin sender_idle_pct = 0;  receiver_stall_pct = 68; end
         default: begin sender_idle_pct = 32; receiver_stall_pct = 32; end
      endcase
      write_csr(REG_IMAGE_WIDTH, w);
      write_csr(REG_IMAGE_HEIGHT, h);
      setting_count++;
      if (fresh || frame_width(w) > old_w) push_req(ACT_CLEAR, 8'h00, 8'h00);
   endtask

   initial begin
      logic [7:0] pattern [16];
      logic [CFG_BITS-1:0] rw, rh;
      pattern = '{8'h00, 8'hFF, 8'h00, 8'hFF, 8'hFF, 8'h00, 8'hFF, 8'h00,
                  8'h00, 8'h00, 8'hFF, 8'hFF, 8'hFF, 8'h80, 8'h01, 8'h00};
      foreach (above_line[i]) above_line[i] = '0;
      foreach (middle_line[i]) middle_line[i] = '0;
      foreach (bin_counts[i]) bin_counts[i] = '0;
      repeat (12) @(posedge clock);
      reset <= 1'b0;

      // directed: reset values, a 4x4 frame, ignored requests, clear
      push_req(ACT_READ, 8'h00, 8'h00);
      push_req(ACT_UNUSED, 8'hFF, 8'hFF);
      set_frame(11'd4, 11'd4, 1'b0);
      foreach (pattern[i]) push_req(ACT_PIXEL, pattern[i], 8'h00);
      push_req(ACT_PIXEL, 8'hFF, 8'hFF);
      push_req(ACT_UNUSED, 8'hFF, 8'hFF);
      push_req(ACT_READ, 8'h00, 8'h00);
      push_req(ACT_READ, 8'h00, 8'hFF);
      push_req(ACT_READ, 8'hFF, 8'h81);
      push_req(ACT_CLEAR, 8'hFF, 8'hFF);
      push_req(ACT_READ, 8'h00, 8'h00);

      // largest frame
      set_frame(11'h7FF, 11'h7FF, 1'b1);
      queue_mix(100, 1, 0, 0);
      set_frame(11'd1024, 11'd4, 1'b1);
      queue_mix(40, 10, 0, 5);

      // degenerate sizes
      set_frame(11'd0, 11'd5, 1'b1);
      queue_mix(30, 15, 3, 5);
      set_frame(11'd1, 11'd0, 1'b0);
      queue_mix(25, 15, 3, 5);
      set_frame(11'd3, 11'd1024, 1'b1);
      queue_mix(30, 15, 3, 5);
      set_frame(11'd6, 11'd3, 1'b1);
      queue_mix(30, 15, 3, 5);

      // width lowered while a line is in progress
      set_frame(11'd12, 11'd8, 1'b1);
      queue_mix(30, 0, 0, 0);
      set_frame(11'd5, 11'd8, 1'b0);
      queue_mix(50, 10, 2, 4);

      // random frames
      set_frame(11'd64, 11'd64, 1'b1);
      queue_mix(150, 5, 0, 2);
      for (int k = 0; k < 6; k++) begin
         rw = ($urandom_range(9) == 0) ? 11'($urandom_range(3)) : 11'($urandom_range(12, 4));
         rh = ($urandom_range(9) == 0) ? 11'($urandom_range(3)) : 11'($urandom_range(9, 4));
         set_frame(rw, rh, 1'($urandom_range(1)));
         queue_mix(25, 10, 3, 4);
      end

      drain_block();
      $display("Covered %0d pixel requests and %0d bin reads over %0d frame settings,",
               pixel_count, read_count, setting_count);
      $display("from zero-sized and sub-4 frames up to the 1024-pixel maximum.");
      if (error_count == 0) begin
         $display("RESULT: OK");
      end else begin
         $display("RESULT: ERROR");
      end
      $finish;
   end

endmodule
